### sv/hte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hte_pkg;

    // Parser phase, one-hot
    typedef enum logic [6:0] {
        PH_SEEK     = 7'b0000001,
        PH_FIRST    = 7'b0000010,
        PH_BANG     = 7'b0000100,
        PH_BANGDASH = 7'b0001000,
        PH_COMMENT  = 7'b0010000,
        PH_BODY     = 7'b0100000,
        PH_ESCAPE   = 7'b1000000
    } phase_t;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        phase_t     phase;
        logic       in_string;
        logic [7:0] last_out;
        logic [7:0] before_last_out;
    } state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       tag_end;
        logic       cut_by_stream_end;
    } result_t;

endpackage

`default_nettype wire

### sv/hte_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One parser step: current state plus one input word -> next state and
// at most one result word.
module hte_step (
    input  wire hte_pkg::state_t  cur,
    input  wire logic [7:0]       in_byte,
    input  wire logic             end_of_stream,
    output hte_pkg::state_t       nxt,
    output logic                  has_res,
    output hte_pkg::result_t      res
);

    logic       do_byte;
    logic       do_end;
    logic       do_cut;
    logic [7:0] byte_val;
    logic       body_ws;
    logic       cmt_ws;

    assign body_ws = (in_byte inside {hte_pkg::CH_SPACE, hte_pkg::CH_TAB, hte_pkg::CH_LF,
                                      hte_pkg::CH_VT, hte_pkg::CH_CR});
    assign cmt_ws  = body_ws || (in_byte == hte_pkg::CH_FF);

    always_comb
    begin
        nxt      = cur;
        do_byte  = 1'b0;
        do_end   = 1'b0;
        do_cut   = 1'b0;
        byte_val = in_byte;

        if (end_of_stream)
        begin
            case (cur.phase)
                hte_pkg::PH_BANG, hte_pkg::PH_BANGDASH, hte_pkg::PH_COMMENT,
                hte_pkg::PH_BODY, hte_pkg::PH_ESCAPE:
                begin
                    do_end = 1'b1;
                    do_cut = 1'b1;
                end
                default:
                begin
                    nxt.phase     = hte_pkg::PH_SEEK;
                    nxt.in_string = 1'b0;
                end
            endcase
        end
        else
        begin
            case (cur.phase)
                hte_pkg::PH_FIRST:
                begin
                    if (in_byte == hte_pkg::CH_GT)
                        do_end = 1'b1;
                    else
                    begin
                        nxt.phase = (in_byte == hte_pkg::CH_BANG) ? hte_pkg::PH_BANG
                                                                  : hte_pkg::PH_BODY;
                        do_byte = 1'b1;
                    end
                end
                hte_pkg::PH_BANG:
                begin
                    if (in_byte == hte_pkg::CH_GT)
                        do_end = 1'b1;
                    else
                    begin
                        nxt.phase = (in_byte == hte_pkg::CH_DASH) ? hte_pkg::PH_BANGDASH
                                                                  : hte_pkg::PH_BODY;
                        do_byte = 1'b1;
                    end
                end
                hte_pkg::PH_BANGDASH:
                begin
                    if (in_byte == hte_pkg::CH_GT)
                        do_end = 1'b1;
                    else
                    begin
                        nxt.phase = hte_pkg::PH_COMMENT;
                        do_byte   = 1'b1;
                    end
                end
                hte_pkg::PH_COMMENT:
                begin
                    // closes only after two dashes were emitted
                    if (in_byte == hte_pkg::CH_GT && cur.last_out == hte_pkg::CH_DASH &&
                        cur.before_last_out == hte_pkg::CH_DASH)
                        do_end = 1'b1;
                    else if (!(cmt_ws && cur.last_out == hte_pkg::CH_SPACE))
                        do_byte = 1'b1;
                end
                hte_pkg::PH_ESCAPE:
                begin
                    nxt.phase = hte_pkg::PH_BODY;
                    do_byte   = 1'b1;
                end
                hte_pkg::PH_BODY:
                begin
                    if (in_byte == hte_pkg::CH_BSLASH)
                    begin
                        nxt.phase = hte_pkg::PH_ESCAPE;
                        do_byte   = 1'b1;
                    end
                    else if (in_byte == hte_pkg::CH_GT)
                    begin
                        if (cur.in_string)
                            do_byte = 1'b1;
                        else
                            do_end = 1'b1;
                    end
                    else if (body_ws)
                    begin
                        if (cur.in_string)
                            do_byte = 1'b1;
                        else if (cur.last_out != hte_pkg::CH_SPACE)
                        begin
                            do_byte  = 1'b1;
                            byte_val = hte_pkg::CH_SPACE;
                        end
                    end
                    else
                    begin
                        if (in_byte == hte_pkg::CH_QUOTE)
                            nxt.in_string = ~cur.in_string;
                        do_byte = 1'b1;
                    end
                end
                default:
                begin
                    // seeking, and any stray phase code
                    if (in_byte == hte_pkg::CH_LT)
                    begin
                        nxt.phase           = hte_pkg::PH_FIRST;
                        nxt.in_string       = 1'b0;
                        nxt.last_out        = 8'h00;
                        nxt.before_last_out = 8'h00;
                    end
                    else
                        nxt.phase = hte_pkg::PH_SEEK;
                end
            endcase
        end

        if (do_byte)
        begin
            nxt.before_last_out = cur.last_out;
            nxt.last_out        = byte_val;
        end
        if (do_end)
        begin
            nxt.phase     = hte_pkg::PH_SEEK;
            nxt.in_string = 1'b0;
        end
    end

    assign has_res               = do_byte || do_end;
    assign res.out_byte          = do_byte ? byte_val : 8'h00;
    assign res.byte_valid        = do_byte;
    assign res.tag_end           = do_end;
    assign res.cut_by_stream_end = do_cut;

endmodule

`default_nettype wire

### sv/html_tag_extractor.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake          | Word
// ---------+-----------+--------------------+-------------------------------------------
// input    | in        | in_valid/in_ready  | in_byte[7:0], end_of_stream
// result   | out       | out_valid/out_ready| out_byte[7:0], byte_valid, tag_end,
//          |           |                    | cut_by_stream_end
//
// Flow: an accepted word lands in the input register; when that word retires, the parser
//   step updates the state and loads the result register, which offers the result.
// Throughput: one word per cycle while a word with a result is not held by a full result register.
// Reset: parser returns to seeking '<', string mode and the emit history clear.
// Stalls: a word that yields no result retires without waiting on the output;
//   one that yields a result waits only while the result register is still full.
module html_tag_extractor (
    input  wire  logic       clk,
    input  wire  logic       rst_n,
    input  wire  logic       in_valid,
    output logic             in_ready,
    input  wire  logic [7:0] in_byte,
    input  wire  logic       end_of_stream,
    output logic             out_valid,
    input  wire  logic       out_ready,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             tag_end,
    output logic             cut_by_stream_end
);

    // input register
    logic                in_vld_reg;
    logic [7:0]          byte_reg;
    logic                eos_reg;

    // parser state
    hte_pkg::state_t     state_reg;
    hte_pkg::state_t     state_next;

    // result register
    logic                out_vld_reg;
    hte_pkg::result_t    res_reg;

    logic                has_res;
    hte_pkg::result_t    res;
    logic                advance;

    hte_step u_step (
        .cur           (state_reg),
        .in_byte       (byte_reg),
        .end_of_stream (eos_reg),
        .nxt           (state_next),
        .has_res       (has_res),
        .res           (res)
    );

    // Held word retires when it has no result or the result slot frees up.
    assign advance  = in_vld_reg && (!has_res || !out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
            eos_reg  <= end_of_stream;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase           <= hte_pkg::PH_SEEK;
            state_reg.in_string       <= 1'b0;
            state_reg.last_out        <= 8'h00;
            state_reg.before_last_out <= 8'h00;
        end
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance && has_res)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_res)
            res_reg <= res;
    end

    assign out_valid         = out_vld_reg;
    assign out_byte          = res_reg.out_byte;
    assign byte_valid        = res_reg.byte_valid;
    assign tag_end           = res_reg.tag_end;
    assign cut_by_stream_end = res_reg.cut_by_stream_end;

    // a result is either a text byte or a terminator, never both
    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid != tag_end))
        else $error("result is neither a single byte nor a single terminator");

    a_cut_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cut_by_stream_end |-> tag_end)
        else $error("stream cut flagged on a non-terminator");

    a_end_to_seek: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.tag_end |=> state_reg.phase == hte_pkg::PH_SEEK &&
                                   !state_reg.in_string)
        else $error("parser not back to seeking after a terminator");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> in_ready)
        else $error("input stalled with an empty input register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && in_vld_reg && has_res |-> !advance)
        else $error("pending result would be overwritten");

endmodule

`default_nettype wire
